/* rtl/cre_pkg.sv */
// shared types and constants of the character range expander
// used by every module of the block, depends on nothing

package cre_pkg;

  // run length of one expansion: at most 24 bytes between a and z
  localparam int unsigned CntW = 5;

  // default depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

  // input word
  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       text_end;
  } out_word_t;

  // command from front to back: an optional run, then an optional final byte
  typedef struct packed {
    logic            emit_a;
    logic [7:0]      a_start;
    logic [CntW-1:0] a_cnt;
    logic            a_down;
    logic            emit_b;
    logic [7:0]      b_char;
  } cmd_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* rtl/cre_front.sv */
// front of the character range expander: takes text words, tracks lookahead
// and turns each word into a command; depends on cre_pkg

module cre_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cre_pkg::in_word_t in_word_i,
  input  cre_pkg::qstat_t   q_stat_i,
  output logic              push_o,
  output cre_pkg::cmd_t     cmd_o
);

  localparam logic [7:0] DashChar = 8'h2D;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_LOWER,
    CLS_UPPER,
    CLS_DIGIT
  } cls_e;

  function automatic cls_e class_of(input logic [7:0] ch);
    cls_e cls;
    cls = CLS_NONE;
    if (ch >= 8'h61 && ch <= 8'h7A) cls = CLS_LOWER;
    else if (ch >= 8'h41 && ch <= 8'h5A) cls = CLS_UPPER;
    else if (ch >= 8'h30 && ch <= 8'h39) cls = CLS_DIGIT;
    return cls;
  endfunction

  logic [7:0] before_q, before_d;
  logic [7:0] pend_q, pend_d;
  logic       have_pend_q, have_pend_d;
  logic       have_before_q, have_before_d;

  logic       accept;
  logic [7:0] x;
  logic       last;
  logic       down;
  logic [7:0] diff;
  logic       range_ok;
  cls_e       cls_c;

  assign x          = in_word_i.in_char;
  assign last       = in_word_i.is_last;
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  // range check between the raw neighbors of the pending byte
  always_comb begin
    cls_c    = class_of(before_q);
    down     = before_q > x;
    diff     = down ? (before_q - x) : (x - before_q);
    range_ok = (cls_c != CLS_NONE) && (cls_c == class_of(x)) && (diff != 8'd1);
  end

  // command build and lookahead update
  always_comb begin
    cmd_o         = '0;
    before_d      = before_q;
    pend_d        = pend_q;
    have_pend_d   = have_pend_q;
    have_before_d = have_before_q;
    cmd_o.emit_b  = last;
    cmd_o.b_char  = x;
    if (!have_before_q) begin
      cmd_o.emit_a  = !last;
      cmd_o.a_start = x;
      cmd_o.a_cnt   = cre_pkg::CntW'(1);
      before_d      = x;
      have_before_d = 1'b1;
      have_pend_d   = 1'b0;
    end else begin
      if (have_pend_q) begin
        if (pend_q == DashChar && range_ok) begin
          cmd_o.emit_a  = diff > 8'd1;
          cmd_o.a_down  = down;
          cmd_o.a_start = down ? (before_q - 8'd1) : (before_q + 8'd1);
          cmd_o.a_cnt   = cre_pkg::CntW'(diff - 8'd1);
        end else begin
          cmd_o.emit_a  = 1'b1;
          cmd_o.a_start = pend_q;
          cmd_o.a_cnt   = cre_pkg::CntW'(1);
        end
        before_d = pend_q;
      end
      pend_d      = x;
      have_pend_d = 1'b1;
    end
    if (last) begin
      before_d      = '0;
      pend_d        = '0;
      have_pend_d   = 1'b0;
      have_before_d = 1'b0;
    end
  end

  assign push_o = accept && (cmd_o.emit_a || cmd_o.emit_b);

  // lookahead registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q      <= '0;
      pend_q        <= '0;
      have_pend_q   <= 1'b0;
      have_before_q <= 1'b0;
    end else if (accept) begin
      before_q      <= before_d;
      pend_q        <= pend_d;
      have_pend_q   <= have_pend_d;
      have_before_q <= have_before_d;
    end
  end

endmodule

/* rtl/cre_queue.sv */
// command queue between front and back of the character range expander
// small register fifo; depends on cre_pkg

module cre_queue #(
  parameter int unsigned DEPTH = cre_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cre_pkg::cmd_t   cmd_i,
  input  logic            pop_i,
  output cre_pkg::cmd_t   cmd_o,
  output cre_pkg::qstat_t stat_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned FillW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  cre_pkg::cmd_t   slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;

  assign stat_o.full  = fill_q == FillW'(DEPTH);
  assign stat_o.empty = fill_q == '0;
  assign cmd_o        = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/cre_back.sv */
// back of the character range expander: runs commands out one byte a cycle
// into the output register unless the output is stalled; depends on cre_pkg

module cre_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cre_pkg::cmd_t      cmd_i,
  input  cre_pkg::qstat_t    q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cre_pkg::out_word_t out_word_o
);

  logic [cre_pkg::CntW-1:0] cnt_q;
  logic [7:0]               cur_q;
  logic                     down_q;
  logic                     has_b_q;
  logic [7:0]               b_char_q;
  logic                     out_valid_q;
  cre_pkg::out_word_t       out_q, out_d;

  logic busy, out_free, advance, done, load;

  assign busy     = (cnt_q != '0) || has_b_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = busy && out_free;
  assign done     = ((cnt_q == cre_pkg::CntW'(1)) && !has_b_q) ||
                    ((cnt_q == '0) && has_b_q);
  assign load     = !q_stat_i.empty && (!busy || (advance && done));
  assign pop_o    = load;

  // next output word
  always_comb begin
    if (cnt_q != '0) begin
      out_d.out_char = cur_q;
      out_d.run_end  = (cnt_q == cre_pkg::CntW'(1)) && !has_b_q;
      out_d.text_end = 1'b0;
    end else begin
      out_d.out_char = b_char_q;
      out_d.run_end  = 1'b1;
      out_d.text_end = 1'b1;
    end
  end

  // run sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      has_b_q  <= 1'b0;
      cur_q    <= '0;
      down_q   <= 1'b0;
      b_char_q <= '0;
    end else begin
      if (advance) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
          cur_q <= down_q ? (cur_q - 8'd1) : (cur_q + 8'd1);
        end else begin
          has_b_q <= 1'b0;
        end
      end
      if (load) begin
        cnt_q    <= cmd_i.emit_a ? cmd_i.a_cnt : '0;
        cur_q    <= cmd_i.a_start;
        down_q   <= cmd_i.a_down;
        has_b_q  <= cmd_i.emit_b;
        b_char_q <= cmd_i.b_char;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/char_range_expander.sv */
// Character range expander. Text bytes come in one word per cycle with a
// last-byte mark; a dash between two bytes of one class (a-z, A-Z, 0-9) that
// are not one apart becomes the bytes strictly between them, up or down, and
// equal neighbors make the dash vanish. The front takes one word per cycle
// while the command queue (QUEUE_DEPTH commands, at least 2) has room; the
// back emits one output byte per cycle while out_stall_i is low; one word
// releases up to 25 bytes. The first byte of a text is released at once,
// every other byte one word later, and the last byte closes the text. An
// input reaches the output via a queue slot, run registers and output register.
// depends on cre_pkg, cre_front, cre_queue and cre_back

module char_range_expander #(
  parameter int unsigned QUEUE_DEPTH = cre_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cre_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cre_pkg::out_word_t out_word_o
);

  logic            q_push, q_pop;
  cre_pkg::cmd_t   cmd_in, cmd_out;
  cre_pkg::qstat_t q_stat;

  cre_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .cmd_o      (cmd_in)
  );

  cre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (cmd_in),
    .pop_i  (q_pop),
    .cmd_o  (cmd_out),
    .stat_o (q_stat)
  );

  cre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full) else $error("push into full command queue");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty) else $error("pop from empty command queue");

  // end of text always closes a run
  a_text_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.text_end |-> out_word_o.run_end)
    else $error("text end without run end");

  // queued commands always carry at least one byte
  a_cmd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (cmd_in.emit_b || (cmd_in.emit_a && cmd_in.a_cnt != '0)))
    else $error("empty command queued");
`endif

endmodule

/* tb/tb_char_range_expander.sv */
// testbench for char_range_expander: streams directed and random texts in,
// predicts every emitted byte and checks the output words in order
// depends on cre_pkg and the char_range_expander rtl

module tb_char_range_expander;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit  = 1000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxReports  = 10;
  localparam logic [7:0]  Dash        = 8'h2D;

  typedef enum int {ClsNone, ClsLower, ClsUpper, ClsDigit} char_cls_e;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  cre_pkg::in_word_t  in_word   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  cre_pkg::out_word_t out_word;

  // words waiting to be sent, bytes still owed by the block
  cre_pkg::in_word_t  feed_q[$];
  cre_pkg::out_word_t out_due[$];
  cre_pkg::out_word_t want;

  // predictor state
  logic [7:0] raw_prev   = '0;
  logic [7:0] held_char  = '0;
  bit         held_valid = 1'b0;
  bit         text_open  = 1'b0;

  int unsigned errors       = 0;
  int unsigned n_in         = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned still_cycles = 0;
  logic        quiet        = 1'b0;

  char_range_expander dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #10 clk_i = ~clk_i;

  function automatic char_cls_e char_class(logic [7:0] ch);
    if (ch >= 8'h61 && ch <= 8'h7A) return ClsLower;
    if (ch >= 8'h41 && ch <= 8'h5A) return ClsUpper;
    if (ch >= 8'h30 && ch <= 8'h39) return ClsDigit;
    return ClsNone;
  endfunction

  // same class on both sides and not direct neighbors
  function automatic bit is_range(logic [7:0] lo, logic [7:0] hi);
    int l;
    int h;
    l = lo;
    h = hi;
    if (l + 1 == h || h + 1 == l) return 1'b0;
    return char_class(lo) != ClsNone && char_class(lo) == char_class(hi);
  endfunction

  function automatic cre_pkg::out_word_t byte_word(logic [7:0] ch);
    cre_pkg::out_word_t o;
    o.out_char = ch;
    o.run_end  = 1'b0;
    o.text_end = 1'b0;
    return o;
  endfunction

  // bytes released by one accepted input word
  task automatic predict_expansion(cre_pkg::in_word_t w);
    cre_pkg::out_word_t run[$];
    int        v;
    logic [7:0] x;
    x = w.in_char;
    if (!text_open) begin
      // first byte of a text goes out at once
      run.push_back(byte_word(x));
      if (w.is_last) begin
        run[0].text_end = 1'b1;
        raw_prev  = '0;
        held_char = '0;
      end else begin
        raw_prev  = x;
        text_open = 1'b1;
      end
      held_valid = 1'b0;
    end else begin
      // resolve the held byte against its right neighbor
      if (held_valid) begin
        if (held_char == Dash && is_range(raw_prev, x)) begin
          if (raw_prev < x) begin
            for (v = int'(raw_prev) + 1; v < int'(x); v++) run.push_back(byte_word(v[7:0]));
          end else begin
            for (v = int'(raw_prev) - 1; v > int'(x); v--) run.push_back(byte_word(v[7:0]));
          end
        end else begin
          run.push_back(byte_word(held_char));
        end
        raw_prev = held_char;
      end
      held_char  = x;
      held_valid = 1'b1;
      // final byte closes the text and clears the state
      if (w.is_last) begin
        run.push_back(byte_word(x));
        run[run.size()-1].text_end = 1'b1;
        raw_prev   = '0;
        held_char  = '0;
        held_valid = 1'b0;
        text_open  = 1'b0;
      end
    end
    if (run.size() > 0) run[run.size()-1].run_end = 1'b1;
    foreach (run[i]) out_due.push_back(run[i]);
  endtask

  task automatic push_char(logic [7:0] ch, bit last);
    cre_pkg::in_word_t w;
    w.in_char = ch;
    w.is_last = last;
    feed_q.push_back(w);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] class_char(int cls);
    case (cls)
      0: return 8'h61 + 8'($urandom_range(0, 25));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h30 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // input driver: sends queued words, with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word  <= '0;
      quiet    <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_expansion(in_word);
        n_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          in_word  <= feed_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      quiet <= (feed_q.size() < 40) || (((n_in / 60) % 4) == 3);
    end
  end

  // output stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // output monitor: every accepted word against the oldest owed byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (out_due.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected word: char %h run_end %b text_end %b",
                   out_word.out_char, out_word.run_end, out_word.text_end);
      end else begin
        want = out_due.pop_front();
        if (want.out_char !== out_word.out_char || want.run_end !== out_word.run_end ||
            want.text_end !== out_word.text_end) begin
          errors++;
          if (errors <= MaxReports)
            $display("mismatch: exp char %h run_end %b text_end %b, got %h %b %b",
                     want.out_char, want.run_end, want.text_end,
                     out_word.out_char, out_word.run_end, out_word.text_end);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) still_cycles = 0;
      else still_cycles++;
      if (still_cycles >= WatchLimit) begin
        $display("tb_char_range_expander: done, errors");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [7:0] txt[$];
    int         len;
    int         cls;
    int         r;
    bit         noisy;
    int         n_rand;

    // directed: single bytes, extremes, both directions, empty and kept dash
    push_text("-");
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    push_text("a-z");
    push_text("z-a");
    push_text("a-a");
    push_text("a-b");
    push_text("0-9");
    push_text("-A-Z-");
    push_text("a-Z");

    // random texts, mostly ranges with random content, some pure noise
    n_rand = 0;
    while (n_rand < 280) begin
      txt.delete();
      len   = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
      noisy = ($urandom_range(0, 4) == 0);
      while (txt.size() < len) begin
        r = $urandom_range(0, 9);
        if (noisy) begin
          txt.push_back((r < 3) ? Dash : 8'($urandom_range(0, 255)));
        end else if (r < 5) begin
          cls = $urandom_range(0, 2);
          txt.push_back(class_char(cls));
          txt.push_back(Dash);
          txt.push_back(class_char(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : cls));
        end else if (r < 7) begin
          txt.push_back(class_char($urandom_range(0, 2)));
        end else if (r < 8) begin
          txt.push_back(Dash);
        end else begin
          txt.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (txt[i]) push_char(txt[i], i == txt.size() - 1);
      n_rand += txt.size();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all words sent, all bytes back, then a few more cycles
    while (feed_q.size() > 0 || in_valid) @(posedge clk_i);
    while (out_due.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0 && out_due.size() == 0) begin
      $display("tb_char_range_expander: done, clean");
    end else begin
      $display("tb_char_range_expander: done, errors");
    end
    $finish;
  end

endmodule
